[rtl/ibe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibe_pkg
// Shared types, sizes and opcode constants of the instruction byte encoder.
// ----------------------------------------------------------------------------
package ibe_pkg;

    localparam int BUFFER_BYTES = 8192;
    localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
    localparam int OFFSET_W     = 13;
    localparam int MAX_BYTES    = 6;
    localparam int CNT_W        = $clog2(MAX_BYTES + 1);
    localparam int IDX_W        = $clog2(MAX_BYTES);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        MODE_NONE  = 4'd0,
        MODE_MOVRR = 4'd1,
        MODE_MOVRI = 4'd2,
        MODE_ADDRR = 4'd3,
        MODE_CMPRR = 4'd4,
        MODE_ADDRI = 4'd5,
        MODE_CMPRI = 4'd6,
        MODE_INC   = 4'd7,
        MODE_JMP   = 4'd8,
        MODE_CALL  = 4'd9,
        MODE_JE    = 4'd10,
        MODE_RET   = 4'd11,
        MODE_PUSH  = 4'd12,
        MODE_POP   = 4'd13,
        MODE_NOP   = 4'd14,
        MODE_CLEAR = 4'd15
    } t_mode;

    localparam logic [7:0] OP_MOV_RR  = 8'h89;
    localparam logic [7:0] OP_MOV_RI  = 8'hB8;
    localparam logic [7:0] OP_ADD_RR  = 8'h01;
    localparam logic [7:0] OP_CMP_RR  = 8'h39;
    localparam logic [7:0] OP_ALU_RI  = 8'h81;
    localparam logic [7:0] OP_INC     = 8'h40;
    localparam logic [7:0] OP_JMP     = 8'hE9;
    localparam logic [7:0] OP_CALL    = 8'hE8;
    localparam logic [7:0] OP_TWO     = 8'h0F;
    localparam logic [7:0] OP_JE      = 8'h84;
    localparam logic [7:0] OP_RET     = 8'hC3;
    localparam logic [7:0] OP_PUSH    = 8'h50;
    localparam logic [7:0] OP_POP     = 8'h58;
    localparam logic [7:0] OP_NOP     = 8'h90;
    localparam logic [1:0] MODRM_REG  = 2'b11;
    localparam logic [2:0] EXT_ADD    = 3'd0;
    localparam logic [2:0] EXT_CMP    = 3'd7;
    localparam logic [31:0] LEN_REL   = 32'd5;
    localparam logic [31:0] LEN_JE    = 32'd6;

    // one classified instruction: bytes in emission order
    typedef struct packed {
        logic                          clear;
        logic [CNT_W-1:0]              count;
        logic [MAX_BYTES-1:0][7:0]     bytes;
    } t_desc;

endpackage
`default_nettype wire

[rtl/ibe_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibe_front
// Classifies one decoded instruction into its byte string and length.
// ----------------------------------------------------------------------------
module ibe_front (
    input  wire logic [3:0]   i_mode,
    input  wire logic [2:0]   i_dest_reg,
    input  wire logic [2:0]   i_src_reg,
    input  wire logic [31:0]  i_immediate,
    input  wire logic [31:0]  i_here_address,
    input  wire logic [31:0]  i_target_address,
    input  wire logic         i_target_found,
    output ibe_pkg::t_desc    o_desc,
    output logic              o_keep
);
    import ibe_pkg::*;

    logic [31:0] rel;
    logic [7:0]  modrm_rr;
    logic [7:0]  modrm_ri;
    t_mode       mode;

    assign mode     = t_mode'(i_mode);
    assign rel      = i_target_address - i_here_address -
                      ((mode == MODE_JE) ? LEN_JE : LEN_REL);
    assign modrm_rr = {MODRM_REG, i_src_reg, i_dest_reg};
    assign modrm_ri = {MODRM_REG, (mode == MODE_ADDRI) ? EXT_ADD : EXT_CMP, i_dest_reg};

    always_comb begin
        o_desc.clear = 1'b0;
        o_desc.count = '0;
        o_desc.bytes = '0;
        case (mode)
            MODE_MOVRR, MODE_ADDRR, MODE_CMPRR: begin
                o_desc.bytes[0] = (mode == MODE_MOVRR) ? OP_MOV_RR :
                                  (mode == MODE_ADDRR) ? OP_ADD_RR : OP_CMP_RR;
                o_desc.bytes[1] = modrm_rr;
                o_desc.count    = CNT_W'(2);
            end
            MODE_MOVRI: begin
                o_desc.bytes[0] = OP_MOV_RI | {5'd0, i_dest_reg};
                o_desc.bytes[1] = i_immediate[7:0];
                o_desc.bytes[2] = i_immediate[15:8];
                o_desc.bytes[3] = i_immediate[23:16];
                o_desc.bytes[4] = i_immediate[31:24];
                o_desc.count    = CNT_W'(5);
            end
            MODE_ADDRI, MODE_CMPRI: begin
                o_desc.bytes[0] = OP_ALU_RI;
                o_desc.bytes[1] = modrm_ri;
                o_desc.bytes[2] = i_immediate[7:0];
                o_desc.bytes[3] = i_immediate[15:8];
                o_desc.bytes[4] = i_immediate[23:16];
                o_desc.bytes[5] = i_immediate[31:24];
                o_desc.count    = CNT_W'(6);
            end
            MODE_INC:  begin
                o_desc.bytes[0] = OP_INC | {5'd0, i_dest_reg};
                o_desc.count    = CNT_W'(1);
            end
            MODE_JMP, MODE_CALL: begin
                if (i_target_found) begin
                    o_desc.bytes[0] = (mode == MODE_JMP) ? OP_JMP : OP_CALL;
                    o_desc.bytes[1] = rel[7:0];
                    o_desc.bytes[2] = rel[15:8];
                    o_desc.bytes[3] = rel[23:16];
                    o_desc.bytes[4] = rel[31:24];
                    o_desc.count    = CNT_W'(5);
                end
            end
            MODE_JE: begin
                if (i_target_found) begin
                    o_desc.bytes[0] = OP_TWO;
                    o_desc.bytes[1] = OP_JE;
                    o_desc.bytes[2] = rel[7:0];
                    o_desc.bytes[3] = rel[15:8];
                    o_desc.bytes[4] = rel[23:16];
                    o_desc.bytes[5] = rel[31:24];
                    o_desc.count    = CNT_W'(6);
                end
            end
            MODE_RET: begin
                o_desc.bytes[0] = OP_RET;
                o_desc.count    = CNT_W'(1);
            end
            MODE_PUSH: begin
                o_desc.bytes[0] = OP_PUSH | {5'd0, i_dest_reg};
                o_desc.count    = CNT_W'(1);
            end
            MODE_POP: begin
                o_desc.bytes[0] = OP_POP | {5'd0, i_dest_reg};
                o_desc.count    = CNT_W'(1);
            end
            MODE_NOP: begin
                o_desc.bytes[0] = OP_NOP;
                o_desc.count    = CNT_W'(1);
            end
            MODE_CLEAR: begin
                o_desc.clear = 1'b1;
            end
            default: begin
                o_desc.clear = 1'b0;
            end
        endcase
    end

    // items that neither emit nor clear never enter the queue
    assign o_keep = o_desc.clear || (o_desc.count != '0);

endmodule
`default_nettype wire

[rtl/ibe_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibe_queue
// Short descriptor queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module ibe_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire ibe_pkg::t_desc  i_desc,
    input  wire logic            i_rd,
    output logic                 o_full,
    output logic                 o_valid,
    output ibe_pkg::t_desc       o_desc
);
    import ibe_pkg::*;

    t_desc              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QPTR_W-1:0]  n_wp;
    logic [QPTR_W-1:0]  n_rp;
    logic [QCNT_W-1:0]  n_cnt;
    logic               do_wr;
    logic               do_rd;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_comb begin
        n_wp  = do_wr ? QPTR_W'(r_wp + 1'b1) : r_wp;
        n_rp  = do_rd ? QPTR_W'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_cnt != QCNT_W'(QUEUE_DEPTH)) |-> (r_wp != r_rp))
        else $error("queue pointers disagree with count");
    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full)) else $error("write into full queue");

endmodule
`default_nettype wire

[rtl/ibe_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibe_back
// Byte sequencer: walks one descriptor a byte per cycle while the result slot
// is free, tracks the buffer write position and drives the result register.
// ----------------------------------------------------------------------------
module ibe_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire ibe_pkg::t_desc         i_q_desc,
    output logic                        o_q_rd,
    input  wire logic                   i_pop,
    output logic                        o_empty,
    output logic [7:0]                  o_code_byte,
    output logic [ibe_pkg::OFFSET_W-1:0] o_byte_offset,
    output logic                        o_last_byte
);
    import ibe_pkg::*;

    logic                       r_busy;
    logic [CNT_W-1:0]           r_cnt;
    logic [IDX_W-1:0]           r_idx;
    logic [MAX_BYTES-1:0][7:0]  r_bytes;
    logic [POS_W-1:0]           r_pos;
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic [OFFSET_W-1:0]        r_out_off;
    logic                       r_out_last;

    logic                       n_busy;
    logic [CNT_W-1:0]           n_cnt;
    logic [IDX_W-1:0]           n_idx;
    logic [MAX_BYTES-1:0][7:0]  n_bytes;
    logic [POS_W-1:0]           n_pos;
    logic                       n_out_valid;

    logic slot_free;
    logic pos_full;
    logic at_cap;
    logic is_last;
    logic emit;
    logic finish;
    logic take;

    assign slot_free = !r_out_valid || i_pop;
    assign pos_full  = (r_pos >= POS_W'(BUFFER_BYTES));
    assign at_cap    = (r_pos == POS_W'(BUFFER_BYTES - 1));
    assign is_last   = (CNT_W'(r_idx) == CNT_W'(r_cnt - 1'b1));
    assign emit      = r_busy && !pos_full && slot_free;
    // stored byte that fills the buffer ends the item as well
    assign finish    = r_busy && (pos_full || (emit && (is_last || at_cap)));
    assign take      = i_q_valid && (!r_busy || finish);
    assign o_q_rd    = take;

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_bytes = r_bytes;
        n_pos   = r_pos;
        if (emit) begin
            n_pos = r_pos + 1'b1;
            n_idx = r_idx + 1'b1;
        end
        if (finish) begin
            n_busy = 1'b0;
        end
        if (take) begin
            n_busy  = !i_q_desc.clear;
            n_cnt   = i_q_desc.count;
            n_idx   = '0;
            n_bytes = i_q_desc.bytes;
            if (i_q_desc.clear) begin
                n_pos = '0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
        end else begin
            r_busy      <= n_busy;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        if (emit) begin
            r_out_byte <= r_bytes[r_idx];
            r_out_off  <= OFFSET_W'(r_pos);
            r_out_last <= is_last || at_cap;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_code_byte   = r_out_byte;
    assign o_byte_offset = r_out_off;
    assign o_last_byte   = r_out_last;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(BUFFER_BYTES)) else $error("write position past capacity");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0 && CNT_W'(r_idx) < r_cnt))
        else $error("sequencer index out of range");
    a_emit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !(take && i_q_desc.clear)) |=> (r_pos == $past(r_pos) + 1'b1))
        else $error("position not advanced on emitted byte");
    a_clear_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_q_desc.clear) |=> (r_pos == '0 && !r_busy))
        else $error("clear did not reset position");

endmodule
`default_nettype wire

[rtl/ia32_instruction_byte_encoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ia32_instruction_byte_encoder_unit
// Turns decoded IA-32 instructions into machine code bytes with buffer offsets.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// input     in         i_push / o_full      mode, regs, immediate, addresses
// result    out        o_empty / i_pop      code byte, byte offset, last flag
//
// an instruction of n bytes (1 to 6) is walked by the byte sequencer one byte
// per cycle into the result register while the result slot is free; a clear
// resets the write position; once the buffer fills, only the stored bytes are
// emitted
// the classifier accepts one item per cycle while the 4-entry queue has room;
// items that neither emit bytes nor clear never enter the queue
// reset is synchronous and clears the position, the queue and the result
// a held result stalls the sequencer, which backs up through the queue to full
// ----------------------------------------------------------------------------
module ia32_instruction_byte_encoder_unit (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    output logic                         o_full,
    input  wire logic [3:0]              i_mode,
    input  wire logic [2:0]              i_dest_reg,
    input  wire logic [2:0]              i_src_reg,
    input  wire logic signed [31:0]      i_immediate,
    input  wire logic [31:0]             i_here_address,
    input  wire logic [31:0]             i_target_address,
    input  wire logic                    i_target_found,
    output logic                         o_empty,
    input  wire logic                    i_pop,
    output logic [7:0]                   o_code_byte,
    output logic [ibe_pkg::OFFSET_W-1:0] o_byte_offset,
    output logic                         o_last_byte
);
    import ibe_pkg::*;

    t_desc front_desc;
    t_desc q_desc;
    logic  front_keep;
    logic  q_full;
    logic  q_valid;
    logic  q_rd;

    ibe_front u_front (
        .i_mode           (i_mode),
        .i_dest_reg       (i_dest_reg),
        .i_src_reg        (i_src_reg),
        .i_immediate      (i_immediate),
        .i_here_address   (i_here_address),
        .i_target_address (i_target_address),
        .i_target_found   (i_target_found),
        .o_desc           (front_desc),
        .o_keep           (front_keep)
    );

    ibe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push && !q_full && front_keep),
        .i_desc  (front_desc),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    ibe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_desc      (q_desc),
        .o_q_rd        (q_rd),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_code_byte   (o_code_byte),
        .o_byte_offset (o_byte_offset),
        .o_last_byte   (o_last_byte)
    );

    assign o_full = q_full;

endmodule
`default_nettype wire
